// ===== rtl/hrlc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrlc_pkg
// Shared constants, types and helpers for the hex record line checker.
// ----------------------------------------------------------------------------
package hrlc_pkg;

  // Character codes
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_F = 8'd70;
  localparam logic [7:0] ALPHA_OFS  = 8'd55;

  // Status codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_CHECKSUM  = 3'd1;
  localparam logic [2:0] STATUS_COUNT     = 3'd2;
  localparam logic [2:0] STATUS_REC_TYPE  = 3'd3;
  localparam logic [2:0] STATUS_MALFORMED = 3'd4;

  // Record types accepted
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_EXT_SEG = 8'h02;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;

  // Digit position tracking: only positions 1, 7 and the 10-digit minimum matter,
  // so the counter saturates at its all-ones value.
  localparam int unsigned CNT_W      = 4;
  localparam logic [CNT_W-1:0] CNT_COUNT_LO = 4'd1;
  localparam logic [CNT_W-1:0] CNT_TYPE_LO  = 4'd7;
  localparam logic [CNT_W-1:0] CNT_MIN      = 4'd10;
  localparam logic [CNT_W-1:0] CNT_SAT      = 4'd15;

  // Configuration
  localparam int unsigned LINE_BITS_DEF   = 16;
  localparam int unsigned PADDR_W         = 3;
  localparam logic [7:0]  MAX_COUNT_RESET = 8'd20;
  localparam logic        REG_MAX_COUNT   = 1'b0;

  // Result carried from the line tracker to the output register
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] line_number;
  } result_t;

  // Hex digit value; anything that is not 0-9 or A-F counts as zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      v = c - ALPHA_OFS;
    end
    return v[3:0];
  endfunction

endpackage

// ===== rtl/hex_record_line_checker.sv =====
// ----------------------------------------------------------------------------
// hex_record_line_checker
// Checks hex-record text one character per beat and reports one status per line.
// ----------------------------------------------------------------------------
// One character is accepted every cycle unless the input stalls. Each character
// is registered, then applied to the line tracker; a line feed loads the status
// and line number into the output register as it leaves the input register.
// The output register lets the next characters flow while a status waits; only
// a line feed arriving while a status is still held stalls the input. Colons
// are skipped and produce nothing.
module hex_record_line_checker #(
  parameter int unsigned LINE_BITS = hrlc_pkg::LINE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // character input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   character_i,
  // status output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   status_o,
  output logic [15:0]                  line_number_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hrlc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import hrlc_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_nl;
  logic       s1_adv;
  logic       out_free;
  logic       out_valid_q;
  result_t    out_q;
  result_t    line_res;
  logic [7:0] max_count;

  hrlc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_count_o (max_count)
  );

  // Stage handshake: a line feed needs a free output slot
  assign s1_nl      = (s1_char_q == CH_NEWLINE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_nl || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_char_q <= character_i;
    end
  end

  hrlc_line #(
    .LINE_BITS (LINE_BITS)
  ) u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .char_i      (s1_char_q),
    .max_count_i (max_count),
    .result_o    (line_res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_nl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_nl) begin
      out_q <= line_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign line_number_o = out_q.line_number;

endmodule

// ===== rtl/hrlc_cfg.sv =====
// ----------------------------------------------------------------------------
// hrlc_cfg
// APB register file holding the largest allowed record byte count.
// ----------------------------------------------------------------------------
module hrlc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hrlc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [7:0]                  max_count_o
);
  import hrlc_pkg::*;

  logic [7:0] max_count_q;
  logic       wr_en;

  // Write on the access phase; register index is the word address
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_COUNT);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= MAX_COUNT_RESET;
    end else if (wr_en) begin
      max_count_q <= pwdata[7:0];
    end
  end

  // Read mux; unmapped index reads zero
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_MAX_COUNT) begin
      prdata = {24'd0, max_count_q};
    end
  end

  assign max_count_o = max_count_q;

endmodule

// ===== rtl/hrlc_line.sv =====
// ----------------------------------------------------------------------------
// hrlc_line
// Per-line tracker: pairs digits into bytes, keeps the running sum, count and
// type bytes and the line counter, and derives the status of the open line.
// ----------------------------------------------------------------------------
module hrlc_line #(
  parameter int unsigned LINE_BITS = hrlc_pkg::LINE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [7:0]        char_i,
  input  logic [7:0]        max_count_i,
  output hrlc_pkg::result_t result_o
);
  import hrlc_pkg::*;

  logic [7:0]           sum_q, sum_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [3:0]           high_q, high_d;
  logic                 half_q, half_d;
  logic [7:0]           count_q, count_d;
  logic [7:0]           type_q, type_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [3:0]           nib;
  logic [7:0]           full_byte;
  logic                 type_ok;

  assign nib       = hex_nibble(char_i);
  assign full_byte = {high_q, nib};

  // Next-state for one character
  always_comb begin
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    high_d  = high_q;
    half_d  = half_q;
    count_d = count_q;
    type_d  = type_q;
    line_d  = line_q;
    if (char_i == CH_NEWLINE) begin
      sum_d   = 8'd0;
      cnt_d   = '0;
      high_d  = 4'd0;
      half_d  = 1'b0;
      count_d = 8'd0;
      type_d  = 8'd0;
      line_d  = line_q + LINE_BITS'(1);
    end else if (char_i != CH_COLON) begin
      if (!half_q) begin
        high_d = nib;
        half_d = 1'b1;
      end else begin
        sum_d  = sum_q + full_byte;
        half_d = 1'b0;
        if (cnt_q == CNT_COUNT_LO) begin
          count_d = full_byte;
        end else if (cnt_q == CNT_TYPE_LO) begin
          type_d = full_byte;
        end
      end
      if (cnt_q != CNT_SAT) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= 8'd0;
      cnt_q   <= '0;
      high_q  <= 4'd0;
      half_q  <= 1'b0;
      count_q <= 8'd0;
      type_q  <= 8'd0;
      line_q  <= LINE_BITS'(1);
    end else if (adv_i) begin
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      high_q  <= high_d;
      half_q  <= half_d;
      count_q <= count_d;
      type_q  <= type_d;
      line_q  <= line_d;
    end
  end

  // Status of the line as it stands; first failing check wins
  assign type_ok = (type_q == REC_DATA) || (type_q == REC_EOF) ||
                   (type_q == REC_EXT_SEG) || (type_q == REC_EXT_LIN);

  always_comb begin
    if (half_q || (cnt_q < CNT_MIN)) begin
      result_o.status = STATUS_MALFORMED;
    end else if (sum_q != 8'd0) begin
      result_o.status = STATUS_CHECKSUM;
    end else if (count_q > max_count_i) begin
      result_o.status = STATUS_COUNT;
    end else if (!type_ok) begin
      result_o.status = STATUS_REC_TYPE;
    end else begin
      result_o.status = STATUS_OK;
    end
    result_o.line_number = 16'(line_q);
  end

endmodule
